FILE: rtl/jcas_pkg.sv
package jcas_pkg;

  // Fixed field widths and scaling
  localparam int SAMPLE_BITS = 12;
  localparam int OUTPUT_SPAN = 1000;
  localparam int OUT_W       = 11;
  localparam int RAD_W       = 12;
  localparam int RAD_RESET   = 64;

  // Shared multiplier: 13 x 13 unsigned
  localparam int MUL_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Scaled numerator (sample difference times span) and divider step count
  localparam int NUM_W    = $clog2(((2 ** SAMPLE_BITS) - 1) * OUTPUT_SPAN + 1);
  localparam int DIVCNT_W = $clog2(NUM_W + 1);

  // Stream payload widths, whole bytes
  localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // Command codes
  localparam logic CMD_NORMAL = 1'b0;
  localparam logic CMD_CENTER = 1'b1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [NUM_W-1:0]       num_t;

  // Request to the shared divider
  typedef struct packed {
    logic    start;
    num_t    dividend;
    sample_t divisor;
  } div_req_t;

endpackage

FILE: rtl/joystick_calibrated_axis_scaler.sv
// Calibrated two-axis joystick scaler with a radial dead zone.
// Input channel in_*: one transfer carries an X and a Y ADC sample in in_tdata
// and the command in in_tuser (0 normal, 1 also recenter). Result channel
// out_*: one transfer per input item with the scaled X and Y positions,
// two's complement in -1000..1000.
// Each item runs through a small sequencer around one shared 13x13
// multiplier and one bit-serial divider: the dead-zone test (X squared,
// Y squared, compare with the squared radius), then per axis a setup, a
// divider start, 22 divide steps and a wait for done, and a finish step; a
// zero span skips the divider. An item inside the dead zone skips the axis
// steps. in_tready goes high again in the same cycle as out_tvalid.
// in_tready is high only while the sequencer is idle. The result sits in an
// output register; if the receiver still holds the previous result, the
// sequencer waits before loading. cfg_wr_en writes the dead-zone radius;
// write it only when idle.
// Reset (rst_n low, synchronous) empties the output register, sets the
// radius to 64, the axis minima to full scale and the maxima and centers
// to zero (center not yet set).
module joystick_calibrated_axis_scaler
  import jcas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [RAD_W-1:0]      cfg_wr_data,   // deadzone_radius
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // [11:0] x_sample, [23:12] y_sample
  input  logic [0:0]            in_tuser,      // [0] command
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata      // [10:0] x_position, [21:11] y_position
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQR,
    S_SETUP,
    S_START,
    S_WAIT,
    S_FIN,
    S_LOAD
  } state_t;

  state_t               state_r;
  logic [RAD_W-1:0]     rad_r;
  sample_t              min_r [2];
  sample_t              max_r [2];
  sample_t              ctr_r [2];
  sample_t              samp_r [2];
  logic                 cmd_r;
  logic                 axis_r;
  logic [PROD_W-1:0]    acc_r;
  num_t                 num_r;
  sample_t              den_r;
  logic                 lower_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [OUT_W-1:0]     res_r [2];
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_x_r;
  logic [OUT_W-1:0]     out_y_r;

  sample_t              in_x;
  sample_t              in_y;
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 load_ok;

  logic [MUL_W-1:0]     dx;
  logic [MUL_W-1:0]     dy;
  logic [MUL_W-1:0]     dx_abs;
  logic [MUL_W-1:0]     dy_abs;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [PROD_W-1:0]    prod;

  sample_t              v;
  sample_t              c;
  logic                 v_lower;
  sample_t              seg_diff;
  logic [SAMPLE_BITS:0] up_span;
  sample_t              seg_den;
  logic                 seg_neg;

  div_req_t             div_req;
  logic                 div_done;
  num_t                 div_quo;
  logic [OUT_W-1:0]     sat_mag;
  logic [OUT_W-1:0]     axis_res;

  logic [SAMPLE_BITS:0] ctr_sum [2];
  sample_t              ctr_new [2];

  assign in_x     = in_tdata[SAMPLE_BITS-1:0];
  assign in_y     = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_valid_r && out_tready;
  assign load_ok  = !out_valid_r || out_tready;

  // Offsets from the stored center, and their magnitudes
  assign dx     = {1'b0, samp_r[0]} - {1'b0, ctr_r[0]};
  assign dy     = {1'b0, samp_r[1]} - {1'b0, ctr_r[1]};
  assign dx_abs = dx[MUL_W-1] ? (MUL_W'(0) - dx) : dx;
  assign dy_abs = dy[MUL_W-1] ? (MUL_W'(0) - dy) : dy;

  // Segment selection for the current axis
  assign v        = samp_r[axis_r];
  assign c        = ctr_r[axis_r];
  assign v_lower  = v < c;
  assign up_span  = {1'b0, max_r[axis_r]} - {1'b0, c};
  assign seg_neg  = !v_lower && up_span[SAMPLE_BITS];
  assign seg_diff = v_lower ? (v - min_r[axis_r]) : (v - c);
  always_comb begin
    if (v_lower) begin
      seg_den = c - min_r[axis_r];
    end else if (up_span[SAMPLE_BITS]) begin
      seg_den = SAMPLE_BITS'((SAMPLE_BITS+1)'(0) - up_span);
    end else begin
      seg_den = up_span[SAMPLE_BITS-1:0];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      S_SQX: begin
        mul_a = dx_abs;
        mul_b = dx_abs;
      end
      S_SQY: begin
        mul_a = dy_abs;
        mul_b = dy_abs;
      end
      S_SQR: begin
        mul_a = MUL_W'(rad_r);
        mul_b = MUL_W'(rad_r);
      end
      S_SETUP: begin
        mul_a = {1'b0, seg_diff};
        mul_b = MUL_W'(OUTPUT_SPAN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Divider request
  assign div_req.start    = (state_r == S_START) && !zero_r;
  assign div_req.dividend = num_r;
  assign div_req.divisor  = den_r;

  jcas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Map the quotient into the output range, saturating
  assign sat_mag = (div_quo > NUM_W'(OUTPUT_SPAN)) ? OUT_W'(OUTPUT_SPAN)
                                                   : div_quo[OUT_W-1:0];
  always_comb begin
    if (zero_r) begin
      axis_res = '0;
    end else if (lower_r) begin
      axis_res = div_quo[OUT_W-1:0] - OUT_W'(OUTPUT_SPAN);
    end else if (neg_r) begin
      axis_res = OUT_W'(0) - sat_mag;
    end else begin
      axis_res = sat_mag;
    end
  end

  // Center calibration: take the sample if unset, else average down
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ctr_sum[i] = {1'b0, ctr_r[i]} + {1'b0, samp_r[i]};
      ctr_new[i] = (ctr_r[i] == '0) ? samp_r[i] : ctr_sum[i][SAMPLE_BITS:1];
    end
  end

  // Sequencer, calibration state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rad_r       <= RAD_W'(RAD_RESET);
      axis_r      <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        min_r[i] <= '1;
        max_r[i] <= '0;
        ctr_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        rad_r <= cfg_wr_data;
      end
      // Drop the result once taken, unless a new one loads in the same cycle
      if (out_xfer && !(state_r == S_LOAD && load_ok)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            samp_r[0] <= in_x;
            samp_r[1] <= in_y;
            cmd_r     <= in_tuser[0];
            axis_r    <= 1'b0;
            // Widen the calibrated range
            if (in_x < min_r[0]) begin
              min_r[0] <= in_x;
            end else if (in_x > max_r[0]) begin
              max_r[0] <= in_x;
            end
            if (in_y < min_r[1]) begin
              min_r[1] <= in_y;
            end else if (in_y > max_r[1]) begin
              max_r[1] <= in_y;
            end
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          acc_r   <= prod;
          state_r <= S_SQY;
        end
        S_SQY: begin
          acc_r   <= acc_r + prod;
          state_r <= S_SQR;
        end
        S_SQR: begin
          // Inside the dead zone both outputs are zero
          if (acc_r < prod) begin
            res_r[0] <= '0;
            res_r[1] <= '0;
            state_r  <= S_LOAD;
          end else begin
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          num_r   <= prod[NUM_W-1:0];
          den_r   <= seg_den;
          lower_r <= v_lower;
          neg_r   <= seg_neg;
          zero_r  <= (seg_den == '0);
          state_r <= S_START;
        end
        S_START: begin
          state_r <= zero_r ? S_FIN : S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r[axis_r] <= axis_res;
          if (axis_r) begin
            state_r <= S_LOAD;
          end else begin
            axis_r  <= 1'b1;
            state_r <= S_SETUP;
          end
        end
        S_LOAD: begin
          if (load_ok) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res_r[0];
            out_y_r     <= res_r[1];
            if (cmd_r == CMD_CENTER) begin
              ctr_r[0] <= ctr_new[0];
              ctr_r[1] <= ctr_new[1];
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2*OUT_W)'(0), out_y_r, out_x_r};

endmodule

FILE: rtl/jcas_div.sv
module jcas_div
  import jcas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output logic     done,
  output num_t     quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIVCNT_W-1:0]   cnt_r;
  sample_t               rem_r;
  sample_t               den_r;
  num_t                  quo_r;
  logic [SAMPLE_BITS:0]  shifted;
  logic [SAMPLE_BITS+1:0] trial;
  logic                  fits;

  // Bring down the next dividend bit and try a subtract
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign fits    = ~trial[SAMPLE_BITS+1];

  // One quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIVCNT_W'(NUM_W);
        rem_r  <= '0;
        den_r  <= req.divisor;
        quo_r  <= req.dividend;
      end else if (busy_r) begin
        rem_r <= fits ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
        quo_r <= {quo_r[NUM_W-2:0], fits};
        cnt_r <= cnt_r - DIVCNT_W'(1);
        if (cnt_r == DIVCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: tb/tb_joystick_calibrated_axis_scaler.sv
`timescale 1ns / 1ps

module tb_joystick_calibrated_axis_scaler;
  import jcas_pkg::*;

  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  // One scaled result: X and Y deflection
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } position_t;

  // Directed stimulus row; typed rows carry a hand-written expected position
  typedef struct packed {
    logic                    cmd;
    logic [SAMPLE_BITS-1:0]  x;
    logic [SAMPLE_BITS-1:0]  y;
    logic                    typed;
    logic signed [OUT_W-1:0] ex;
    logic signed [OUT_W-1:0] ey;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [RAD_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [11:0] x_sample, [23:12] y_sample
  logic [0:0]            in_tuser = '0;   // [0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [10:0] x_position, [21:11] y_position

  // Typed expectation riding along with the offered transfer
  logic      row_typed = 1'b0;
  position_t row_position = '0;

  // Calibration state of the predictor (index 0 is X, 1 is Y)
  sample_t          axis_lo  [2];
  sample_t          axis_hi  [2];
  sample_t          axis_mid [2];
  logic [RAD_W-1:0] dz_radius;

  position_t expected_pos_q [$];
  int        errors = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        holds_req = 0;
  int        holds_done = 0;

  stim_row_t directed_rows [17] = '{
    '{CMD_NORMAL,   10,   10, 1'b1,     0,     0},  // center unset, inside dead zone
    '{CMD_NORMAL,    0, 4095, 1'b1,     0,  1000},  // zero span on X, full scale on Y
    '{CMD_NORMAL, 4095,    0, 1'b1,  1000,     0},
    '{CMD_CENTER, 2048, 2048, 1'b0,     0,     0},  // first centering takes the sample
    '{CMD_NORMAL, 2048, 2048, 1'b1,     0,     0},
    '{CMD_NORMAL, 2111, 2048, 1'b1,     0,     0},  // just inside the dead zone
    '{CMD_NORMAL, 2048, 2111, 1'b1,     0,     0},
    '{CMD_NORMAL, 2112, 2048, 1'b0,     0,     0},  // on the dead-zone radius
    '{CMD_NORMAL,    0, 4095, 1'b1, -1000,  1000},
    '{CMD_NORMAL, 4095,    0, 1'b1,  1000, -1000},
    '{CMD_NORMAL,    0,    0, 1'b1, -1000, -1000},
    '{CMD_NORMAL, 4095, 4095, 1'b1,  1000,  1000},
    '{CMD_CENTER, 1000, 3000, 1'b0,     0,     0},  // averaging, old center for dead zone
    '{CMD_CENTER, 2047, 2049, 1'b0,     0,     0},  // odd sum rounds down
    '{CMD_NORMAL, 1785, 2286, 1'b1,     0,     0},
    '{CMD_CENTER,    0,    0, 1'b0,     0,     0},
    '{CMD_NORMAL, 2500, 1000, 1'b0,     0,     0}
  };

  joystick_calibrated_axis_scaler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Map one axis segment lo..hi onto out_lo..out_hi, truncate and saturate
  function automatic logic signed [OUT_W-1:0] map_segment(longint v, longint lo,
                                                         longint hi, longint out_lo,
                                                         longint out_hi);
    longint span;
    longint r;
    span = hi - lo;
    if (span == 0) return '0;
    r = (v - lo) * (out_hi - out_lo) / span + out_lo;
    if (r > OUTPUT_SPAN) r = OUTPUT_SPAN;
    if (r < -OUTPUT_SPAN) r = -OUTPUT_SPAN;
    return r[OUT_W-1:0];
  endfunction

  // Widen the calibration, scale both axes, then recenter on a centering sample
  function automatic position_t scale_sample(logic cmd, sample_t sx, sample_t sy);
    sample_t   s [2];
    longint    dx;
    longint    dy;
    longint    dist_sq;
    longint    rad;
    logic      dead;
    logic signed [OUT_W-1:0] pos [2];
    int        a;
    s[0] = sx;
    s[1] = sy;
    for (a = 0; a < 2; a++) begin
      if (s[a] < axis_lo[a]) axis_lo[a] = s[a];
      else if (s[a] > axis_hi[a]) axis_hi[a] = s[a];
    end
    dx = longint'(s[0]) - longint'(axis_mid[0]);
    dy = longint'(s[1]) - longint'(axis_mid[1]);
    dist_sq = dx * dx + dy * dy;
    rad = longint'(dz_radius);
    dead = dist_sq < rad * rad;
    for (a = 0; a < 2; a++) begin
      if (dead) pos[a] = '0;
      else if (s[a] < axis_mid[a])
        pos[a] = map_segment(s[a], axis_lo[a], axis_mid[a], -OUTPUT_SPAN, 0);
      else
        pos[a] = map_segment(s[a], axis_mid[a], axis_hi[a], 0, OUTPUT_SPAN);
    end
    if (cmd == CMD_CENTER) begin
      for (a = 0; a < 2; a++) begin
        if (axis_mid[a] == 0) axis_mid[a] = s[a];
        else axis_mid[a] = sample_t'((13'(axis_mid[a]) + 13'(s[a])) >> 1);
      end
    end
    return '{x: pos[0], y: pos[1]};
  endfunction

  // Random sample: near the current center, at full scale, or anywhere
  function automatic sample_t pick_sample(int a, int kind);
    int v;
    int spread;
    spread = int'(dz_radius) + 16;
    if (kind < 3) begin
      v = $urandom_range(2 * spread);
      v = v - spread + int'(axis_mid[a]);
    end else if (kind == 3) begin
      v = $urandom_range(1) ? SAMPLE_MAX : 0;
    end else begin
      v = $urandom_range(SAMPLE_MAX);
    end
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return sample_t'(v);
  endfunction

  // Track accepted inputs and check results against the oldest expectation
  always @(posedge clk) begin : transfer_check
    position_t calc;
    position_t want;
    position_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        calc = scale_sample(in_tuser[0], in_tdata[11:0], in_tdata[23:12]);
        expected_pos_q.push_back(row_typed ? row_position : calc);
      end
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[OUT_W-1:0];
        got.y = out_tdata[2*OUT_W-1:OUT_W];
        if (expected_pos_q.size() == 0) begin
          $error("unexpected result transfer: x_position %0d, y_position %0d",
                 got.x, got.y);
          errors++;
        end else begin
          want = expected_pos_q.pop_front();
          if (got.x !== want.x) begin
            $error("x_position: expected %0d, got %0d", want.x, got.x);
            errors++;
          end
          if (got.y !== want.y) begin
            $error("y_position: expected %0d, got %0d", want.y, got.y);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      if (holds_done != holds_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Offer one sample after a random gap and hold it until the transfer
  task automatic offer_sample(logic cmd, sample_t x, sample_t y, logic typed,
                              position_t pos);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= {y, x};
    in_tuser     <= cmd;
    row_typed    <= typed;
    row_position <= pos;
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait until every expected result has arrived
  task automatic wait_idle();
    @(posedge clk);
    while (expected_pos_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] r);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    dz_radius = r;
  endtask

  task automatic run_phase(int radius, int snd, int rcv, int count, bit hold);
    int      kind;
    logic    cmd;
    sample_t x;
    sample_t y;
    wait_idle();
    write_radius(radius[RAD_W-1:0]);
    idle_pct  = snd;
    stall_pct = rcv;
    if (hold) holds_req++;
    repeat (count) begin
      kind = $urandom_range(9);
      cmd  = ($urandom_range(3) == 0) ? CMD_CENTER : CMD_NORMAL;
      x    = pick_sample(0, kind);
      y    = pick_sample(1, kind);
      offer_sample(cmd, x, y, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    for (int a = 0; a < 2; a++) begin
      axis_lo[a]  = sample_t'(SAMPLE_MAX);
      axis_hi[a]  = '0;
      axis_mid[a] = '0;
    end
    dz_radius = RAD_W'(RAD_RESET);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset radius
    foreach (directed_rows[i]) begin
      offer_sample(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].typed,
                   '{x: directed_rows[i].ex, y: directed_rows[i].ey});
    end
    in_tvalid <= 1'b0;

    // Random phases: radius, sender idle %, receiver stall %, items, hold-off
    run_phase(100,  0,  0, 150, 1'b0);
    run_phase(0,   70,  0, 130, 1'b0);
    run_phase(4095, 0, 70, 100, 1'b0);
    run_phase($urandom_range(1, 300), 7, 7, 150, 1'b0);
    run_phase(64,   0,  0,  40, 1'b1);
    run_phase(150,  7,  7, 230, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: joystick_calibrated_axis_scaler.f
rtl/jcas_pkg.sv
rtl/jcas_div.sv
rtl/joystick_calibrated_axis_scaler.sv
tb/tb_joystick_calibrated_axis_scaler.sv
